/* hw/rtl/bhrt_pkg.sv */
`timescale 1ns / 1ps

package bhrt_pkg;

    localparam int NUM_BUTTONS_DEF = 19;

    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_DELAY   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_INTERVAL = 2'd2;

    localparam logic [15:0] LONG_PRESS_RST      = 16'd800;
    localparam logic [15:0] REPEAT_DELAY_RST    = 16'd400;
    localparam logic [15:0] REPEAT_INTERVAL_RST = 16'd100;

    localparam logic CMD_LEVEL = 1'b0;
    localparam logic CMD_TICK  = 1'b1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOAD,
        S_CALC,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic               down;
        logic               press;
        logic               armed;
        logic [15:0]        hold;
        logic signed [16:0] countdown;
        logic [11:0]        dt;
        logic [15:0]        long_ms;
        logic [15:0]        delay_ms;
        logic [15:0]        interval_ms;
    } t_alu_in;

    typedef struct packed {
        logic               armed;
        logic               fire;
        logic               long_hold;
        logic [15:0]        hold;
        logic signed [16:0] countdown;
    } t_alu_out;

    typedef struct packed {
        logic [4:0]  button_index;
        logic        is_down;
        logic        pressed_edge;
        logic        released_edge;
        logic        repeat_fire;
        logic        long_hold;
        logic [15:0] hold_ms;
        logic        frame_had_input;
        logic        last_word;
    } t_out_word;

endpackage

/* hw/rtl/bhrt_if.sv */
`timescale 1ns / 1ps

interface bhrt_in_if;
    logic        valid;
    logic        ready;
    logic        cmd;
    logic [4:0]  button;
    logic        level;
    logic [11:0] elapsed_ms;

    modport source (output valid, output cmd, output button, output level,
                    output elapsed_ms, input ready);
    modport sink (input valid, input cmd, input button, input level,
                  input elapsed_ms, output ready);
endinterface

interface bhrt_out_if;
    logic        valid;
    logic        ready;
    logic [4:0]  button_index;
    logic        is_down;
    logic        pressed_edge;
    logic        released_edge;
    logic        repeat_fire;
    logic        long_hold;
    logic [15:0] hold_ms;
    logic        frame_had_input;
    logic        last_word;

    modport source (output valid, output button_index, output is_down,
                    output pressed_edge, output released_edge, output repeat_fire,
                    output long_hold, output hold_ms, output frame_had_input,
                    output last_word, input ready);
    modport sink (input valid, input button_index, input is_down,
                  input pressed_edge, input released_edge, input repeat_fire,
                  input long_hold, input hold_ms, input frame_had_input,
                  input last_word, output ready);
endinterface

interface bhrt_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [bhrt_pkg::CFG_IDX_W-1:0] index;
    logic [15:0]                    data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

/* hw/rtl/bhrt_alu.sv */
`timescale 1ns / 1ps

module bhrt_alu (
    input  bhrt_pkg::t_alu_in  i_op,
    output bhrt_pkg::t_alu_out o_res
);

    logic [15:0]        base;
    logic [16:0]        sum;
    logic [15:0]        hold_sat;
    logic signed [16:0] diff;

    always_comb begin
        // a press this frame restarts the hold time
        base     = i_op.press ? 16'd0 : i_op.hold;
        sum      = {1'b0, base} + {5'd0, i_op.dt};
        hold_sat = sum[16] ? 16'hFFFF : sum[15:0];
        diff     = i_op.countdown - $signed({5'd0, i_op.dt});

        o_res = '0;
        if (i_op.down) begin
            o_res.hold      = hold_sat;
            o_res.long_hold = (hold_sat >= i_op.long_ms);
            o_res.armed     = 1'b1;
            if (!i_op.armed) begin
                o_res.fire      = 1'b1;
                o_res.countdown = $signed({1'b0, i_op.delay_ms});
            end else if (diff <= 17'sd0) begin
                o_res.fire      = 1'b1;
                o_res.countdown = $signed({1'b0, i_op.interval_ms});
            end else begin
                o_res.countdown = diff;
            end
        end
    end

endmodule

/* hw/rtl/button_hold_repeat_tracker.sv */
`timescale 1ns / 1ps

// channel  | dir | handshake   | payload
// i_in     | in  | valid/ready | cmd, button, level, elapsed_ms
// o_out    | out | valid/ready | one status word per button, last_word on the final one
// i_cfg    | in  | valid/ready | index (0..2 used, 3 ignored), data (16 bits); always ready
//
// A level request is taken in idle and updates the button flags. A tick request walks
// the buttons one at a time through the shared update unit: read timers, update,
// emit (held while the output stalls); the next request waits for the last word.
// Reset (synchronous, active low) clears the button flags and loads the register
// defaults; the timer store needs no clearing. Input is held off while a tick runs.

module button_hold_repeat_tracker #(
    parameter int NUM_BUTTONS = bhrt_pkg::NUM_BUTTONS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    bhrt_in_if.sink           i_in,
    bhrt_out_if.source        o_out,
    bhrt_cfg_if.sink          i_cfg
);

    localparam int IW = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;
    localparam logic [IW-1:0] LAST_IDX = IW'(NUM_BUTTONS - 1);

    bhrt_pkg::t_state r_state, n_state;

    logic [15:0] r_long_ms, r_delay_ms, r_interval_ms;

    logic [NUM_BUTTONS-1:0] r_down, r_press, r_release, r_armed;
    logic [IW-1:0]          r_idx;
    logic                   r_had;
    logic [11:0]            r_dt;

    logic [15:0]        mem_hold [NUM_BUTTONS];
    logic signed [16:0] mem_cd   [NUM_BUTTONS];
    logic [15:0]        r_hold_rd;
    logic signed [16:0] r_cd_rd;

    bhrt_pkg::t_out_word r_out;
    bhrt_pkg::t_alu_in   alu_in;
    bhrt_pkg::t_alu_out  alu_out;

    logic in_acc, out_acc, is_last, btn_ok, n_had;
    logic [IW-1:0] btn_idx;

    assign i_cfg.ready = 1'b1;
    assign in_acc  = i_in.valid & i_in.ready;
    assign out_acc = o_out.valid & o_out.ready;
    assign is_last = (r_idx == LAST_IDX);
    assign btn_ok  = ({1'b0, i_in.button} < 6'(NUM_BUTTONS));
    assign btn_idx = i_in.button[IW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bhrt_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        i_in.ready  = 1'b0;
        o_out.valid = 1'b0;
        unique case (r_state)
            bhrt_pkg::S_IDLE: begin
                i_in.ready = 1'b1;
                if (i_in.valid && i_in.cmd == bhrt_pkg::CMD_TICK) begin
                    n_state = bhrt_pkg::S_LOAD;
                end
            end
            bhrt_pkg::S_LOAD: n_state = bhrt_pkg::S_CALC;
            bhrt_pkg::S_CALC: n_state = bhrt_pkg::S_EMIT;
            bhrt_pkg::S_EMIT: begin
                o_out.valid = 1'b1;
                if (o_out.ready) begin
                    n_state = is_last ? bhrt_pkg::S_IDLE : bhrt_pkg::S_LOAD;
                end
            end
            default: n_state = bhrt_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_long_ms     <= bhrt_pkg::LONG_PRESS_RST;
            r_delay_ms    <= bhrt_pkg::REPEAT_DELAY_RST;
            r_interval_ms <= bhrt_pkg::REPEAT_INTERVAL_RST;
        end else if (i_cfg.valid && i_cfg.ready) begin
            unique case (i_cfg.index)
                bhrt_pkg::CFG_LONG_PRESS:      r_long_ms     <= i_cfg.data;
                bhrt_pkg::CFG_REPEAT_DELAY:    r_delay_ms    <= i_cfg.data;
                bhrt_pkg::CFG_REPEAT_INTERVAL: r_interval_ms <= i_cfg.data;
                default: ;
            endcase
        end
    end

    assign alu_in.down        = r_down[r_idx];
    assign alu_in.press       = r_press[r_idx];
    assign alu_in.armed       = r_armed[r_idx];
    assign alu_in.hold        = r_hold_rd;
    assign alu_in.countdown   = r_cd_rd;
    assign alu_in.dt          = r_dt;
    assign alu_in.long_ms     = r_long_ms;
    assign alu_in.delay_ms    = r_delay_ms;
    assign alu_in.interval_ms = r_interval_ms;

    bhrt_alu u_alu (
        .i_op  (alu_in),
        .o_res (alu_out)
    );

    assign n_had = r_had | r_press[r_idx] | r_release[r_idx] | alu_out.fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_down    <= '0;
            r_press   <= '0;
            r_release <= '0;
            r_armed   <= '0;
            r_idx     <= '0;
            r_had     <= 1'b0;
        end else begin
            if (in_acc) begin
                if (i_in.cmd == bhrt_pkg::CMD_TICK) begin
                    r_idx <= '0;
                    r_had <= 1'b0;
                end else if (btn_ok) begin
                    if (i_in.level && !r_down[btn_idx]) begin
                        r_down[btn_idx]  <= 1'b1;
                        r_press[btn_idx] <= 1'b1;
                    end else if (!i_in.level && r_down[btn_idx]) begin
                        r_down[btn_idx]    <= 1'b0;
                        r_release[btn_idx] <= 1'b1;
                    end
                end
            end
            if (r_state == bhrt_pkg::S_CALC) begin
                r_armed[r_idx] <= alu_out.armed;
                r_had          <= n_had;
            end
            if (r_state == bhrt_pkg::S_EMIT && out_acc) begin
                if (is_last) begin
                    // frame done: drop the edge flags
                    r_press   <= '0;
                    r_release <= '0;
                end else begin
                    r_idx <= r_idx + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && i_in.cmd == bhrt_pkg::CMD_TICK) begin
            r_dt <= i_in.elapsed_ms;
        end
        if (r_state == bhrt_pkg::S_LOAD) begin
            r_hold_rd <= mem_hold[r_idx];
            r_cd_rd   <= mem_cd[r_idx];
        end
        if (r_state == bhrt_pkg::S_CALC) begin
            mem_hold[r_idx] <= alu_out.hold;
            mem_cd[r_idx]   <= alu_out.countdown;

            r_out.button_index    <= 5'(r_idx);
            r_out.is_down         <= r_down[r_idx];
            r_out.pressed_edge    <= r_press[r_idx];
            r_out.released_edge   <= r_release[r_idx];
            r_out.repeat_fire     <= alu_out.fire;
            r_out.long_hold       <= alu_out.long_hold;
            r_out.hold_ms         <= alu_out.hold;
            r_out.frame_had_input <= is_last & n_had;
            r_out.last_word       <= is_last;
        end
    end

    assign o_out.button_index    = r_out.button_index;
    assign o_out.is_down         = r_out.is_down;
    assign o_out.pressed_edge    = r_out.pressed_edge;
    assign o_out.released_edge   = r_out.released_edge;
    assign o_out.repeat_fire     = r_out.repeat_fire;
    assign o_out.long_hold       = r_out.long_hold;
    assign o_out.hold_ms         = r_out.hold_ms;
    assign o_out.frame_had_input = r_out.frame_had_input;
    assign o_out.last_word       = r_out.last_word;

endmodule
